@@ rtl/core/lcdlm_pkg.sv @@
// Shared types and constants for the LCD line and mode timing block.
// Used by lcdlm_cfg_regs, lcdlm_step and lcd_line_mode_timing.
`default_nettype none

package lcdlm_pkg;

  // Line geometry in clock cycles
  localparam logic [9:0] LINE_LEN     = 10'd456;
  localparam logic [8:0] LAST_POS     = 9'd455;
  localparam logic [8:0] MODE2_LEN    = 9'd80;
  localparam logic [8:0] MODE3_END    = 9'd252;
  localparam logic [9:0] MODE0_LEN    = 10'd204;

  // Frame geometry in lines
  localparam logic [7:0] VBLANK_FIRST = 8'd144;
  localparam logic [7:0] FRAME_LINES  = 8'd154;
  localparam logic [7:0] LAST_LINE    = 8'd153;

  // Display mode codes
  localparam logic [1:0] MODE_HBLANK   = 2'd0;
  localparam logic [1:0] MODE_VBLANK   = 2'd1;
  localparam logic [1:0] MODE_OAM      = 2'd2;
  localparam logic [1:0] MODE_TRANSFER = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_IRQ_HBLANK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IRQ_VBLANK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IRQ_OAM    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IRQ_MATCH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_CMP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DMA_ARMED  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DISP_EN    = 3'd6;

  typedef struct packed {
    logic       irq_on_hblank;
    logic       irq_on_vblank;
    logic       irq_on_oam_scan;
    logic       irq_on_line_match;
    logic [7:0] line_compare;
    logic       hblank_dma_armed;
    logic       display_enable;
  } cfg_t;

  typedef struct packed {
    logic       line_drawn;
    logic [7:0] drawn_line;
    logic       hblank_dma_pulse;
    logic       stat_irq;
    logic       frame_end;
    logic [1:0] lcd_mode;
    logic [7:0] current_line;
    logic       line_match;
    logic [8:0] cycles_to_event;
    logic       running;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/lcdlm_cfg_regs.sv @@
// Configuration registers of the LCD line and mode timing block.
// Depends on lcdlm_pkg for the register indexes and the cfg_t type.
`default_nettype none

module lcdlm_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [lcdlm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                    cfg_wdata,
  output lcdlm_pkg::cfg_t                    cfg,
  output logic                               disp_off_clr
);

  lcdlm_pkg::cfg_t cfg_r;
  lcdlm_pkg::cfg_t cfg_nxt;

  // Decode the write into the addressed field; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        lcdlm_pkg::CFG_IRQ_HBLANK: cfg_nxt.irq_on_hblank     = cfg_wdata[0];
        lcdlm_pkg::CFG_IRQ_VBLANK: cfg_nxt.irq_on_vblank     = cfg_wdata[0];
        lcdlm_pkg::CFG_IRQ_OAM:    cfg_nxt.irq_on_oam_scan   = cfg_wdata[0];
        lcdlm_pkg::CFG_IRQ_MATCH:  cfg_nxt.irq_on_line_match = cfg_wdata[0];
        lcdlm_pkg::CFG_LINE_CMP:   cfg_nxt.line_compare      = cfg_wdata;
        lcdlm_pkg::CFG_DMA_ARMED:  cfg_nxt.hblank_dma_armed  = cfg_wdata[0];
        lcdlm_pkg::CFG_DISP_EN:    cfg_nxt.display_enable    = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Turning the display off resets the line position and counter
  assign disp_off_clr = cfg_wr_en && (cfg_index == lcdlm_pkg::CFG_DISP_EN) &&
                        !cfg_wdata[0] && cfg_r.display_enable;

  // Hold all settings at zero in reset, with the display enabled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{irq_on_hblank:     1'b0,
                 irq_on_vblank:     1'b0,
                 irq_on_oam_scan:   1'b0,
                 irq_on_line_match: 1'b0,
                 line_compare:      8'd0,
                 hblank_dma_armed:  1'b0,
                 display_enable:    1'b1};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ rtl/core/lcdlm_step.sv @@
// Single-pass timing step: advances line position and counter by the elapsed
// count while the display is enabled, and forms the result. Depends on lcdlm_pkg.
`default_nettype none

module lcdlm_step (
  input  wire lcdlm_pkg::cfg_t cfg,
  input  wire logic [8:0]  pos,
  input  wire logic [7:0]  line,
  input  wire logic [8:0]  elapsed,
  output logic [8:0]       pos_nxt,
  output logic [7:0]       line_nxt,
  output lcdlm_pkg::res_t  res
);

  logic [8:0] e_sat;
  logic [9:0] rem;
  logic [9:0] pos_sum;
  logic [9:0] e_left;
  logic       wrap;
  logic       visible;
  logic       pre_draw;
  logic       draw_a;
  logic [7:0] line_inc;
  logic [7:0] line_w;
  logic       fend;
  logic       draw_w2;
  logic       irq_w;
  logic [8:0] pos_f;
  logic [7:0] line_f;
  logic [1:0] mode_f;
  logic [9:0] to_end;
  logic [9:0] next_ev;
  logic       drawn;
  logic [7:0] dline;

  // Clamp the elapsed count to one line less a cycle
  assign e_sat = (elapsed > lcdlm_pkg::LAST_POS) ? lcdlm_pkg::LAST_POS : elapsed;

  // At most one line wrap fits in one step
  assign rem     = lcdlm_pkg::LINE_LEN - {1'b0, pos};
  assign wrap    = ({1'b0, e_sat} >= rem);
  assign pos_sum = {1'b0, pos} + {1'b0, e_sat};
  assign e_left  = {1'b0, e_sat} - rem;

  // Draw point inside the current line
  assign visible  = (line < lcdlm_pkg::VBLANK_FIRST);
  assign pre_draw = visible && (pos < lcdlm_pkg::MODE3_END);
  assign draw_a   = pre_draw && (pos_sum[8:0] >= lcdlm_pkg::MODE3_END);

  // Next line after a wrap, with frame roll-over
  assign line_inc = line + 8'd1;
  assign fend     = wrap && (line_inc == lcdlm_pkg::VBLANK_FIRST);
  assign line_w   = (line_inc >= lcdlm_pkg::FRAME_LINES) ? 8'd0 : line_inc;
  assign draw_w2  = (line_w < lcdlm_pkg::VBLANK_FIRST) &&
                    (e_left[8:0] >= lcdlm_pkg::MODE3_END);
  assign irq_w    = (cfg.irq_on_vblank && fend) ||
                    (cfg.irq_on_line_match && (line_w == cfg.line_compare)) ||
                    (cfg.irq_on_oam_scan && (line_w < lcdlm_pkg::VBLANK_FIRST));

  // Merge the draw events of both halves of the step
  always_comb begin
    drawn = 1'b0;
    dline = 8'd0;
    if (wrap) begin
      if (pre_draw) begin
        drawn = 1'b1;
        dline = line;
      end else if (draw_w2) begin
        drawn = 1'b1;
        dline = line_w;
      end
    end else if (draw_a) begin
      drawn = 1'b1;
      dline = line;
    end
  end

  assign pos_f  = wrap ? e_left[8:0] : pos_sum[8:0];
  assign line_f = wrap ? line_w : line;

  // Mode after the step
  always_comb begin
    if (line_f >= lcdlm_pkg::VBLANK_FIRST) begin
      mode_f = lcdlm_pkg::MODE_VBLANK;
    end else if (pos_f < lcdlm_pkg::MODE2_LEN) begin
      mode_f = lcdlm_pkg::MODE_OAM;
    end else if (pos_f < lcdlm_pkg::MODE3_END) begin
      mode_f = lcdlm_pkg::MODE_TRANSFER;
    end else begin
      mode_f = lcdlm_pkg::MODE_HBLANK;
    end
  end

  // Next sync point: line end, or mode 0 entry when someone listens for it
  assign to_end  = lcdlm_pkg::LINE_LEN - {1'b0, pos_f};
  assign next_ev = ((cfg.irq_on_hblank || cfg.hblank_dma_armed) &&
                    (mode_f == lcdlm_pkg::MODE_OAM ||
                     mode_f == lcdlm_pkg::MODE_TRANSFER)) ?
                   (to_end - lcdlm_pkg::MODE0_LEN) : to_end;

  // Assemble the transaction; a disabled display holds and reports zeros
  always_comb begin
    res      = '0;
    pos_nxt  = pos;
    line_nxt = line;
    if (cfg.display_enable) begin
      pos_nxt              = pos_f;
      line_nxt             = line_f;
      res.line_drawn       = drawn;
      res.drawn_line       = dline;
      res.hblank_dma_pulse = drawn && cfg.hblank_dma_armed;
      res.stat_irq         = (drawn && cfg.irq_on_hblank) || (wrap && irq_w);
      res.frame_end        = fend;
      res.lcd_mode         = mode_f;
      res.current_line     = line_f;
      res.line_match       = (line_f == cfg.line_compare);
      res.cycles_to_event  = next_ev[8:0];
      res.running          = 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/lcd_line_mode_timing.sv @@
// LCD line and mode timing controller, top level; depends on lcdlm_pkg, lcdlm_cfg_regs, lcdlm_step.
// The single-pass step sits between the input and result registers; a transaction accepted
// into the input register moves its result into the result register once that is empty or taken.
// Throughput: one transaction per cycle; input and result registers both advance
// whenever the result register is empty or taken.
// Reset (rst_n low, synchronous): pipeline empty, counters zero, settings zero but display_enable.
`default_nettype none

module lcd_line_mode_timing (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Input channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [8:0]                      in_elapsed_cycles,
  // Result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_line_drawn,
  output logic [7:0]                           out_drawn_line,
  output logic                                 out_hblank_dma_pulse,
  output logic                                 out_stat_irq,
  output logic                                 out_frame_end,
  output logic [1:0]                           out_lcd_mode,
  output logic [7:0]                           out_current_line,
  output logic                                 out_line_match,
  output logic [8:0]                           out_cycles_to_event,
  output logic                                 out_running,
  // Configuration port
  input  wire logic                            cfg_wr_en,
  input  wire logic [lcdlm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                      cfg_wdata
);

  lcdlm_pkg::cfg_t cfg;
  logic            disp_off_clr;

  logic            in_v_r;
  logic [8:0]      in_e_r;
  logic            out_v_r;
  lcdlm_pkg::res_t res_r;
  lcdlm_pkg::res_t res_nxt;
  logic [8:0]      pos_r;
  logic [8:0]      pos_nxt;
  logic [7:0]      line_r;
  logic [7:0]      line_nxt;

  logic            out_adv;
  logic            step_fire;
  logic            in_fire;

  lcdlm_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .cfg          (cfg),
    .disp_off_clr (disp_off_clr)
  );

  lcdlm_step u_step (
    .cfg      (cfg),
    .pos      (pos_r),
    .line     (line_r),
    .elapsed  (in_e_r),
    .pos_nxt  (pos_nxt),
    .line_nxt (line_nxt),
    .res      (res_nxt)
  );

  // Handshake: result register frees up when empty or taken
  assign out_adv   = !out_v_r || !out_stall;
  assign step_fire = in_v_r && out_adv;
  assign in_stall  = in_v_r && !out_adv;
  assign in_fire   = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_fire) begin
      in_v_r <= 1'b1;
    end else if (step_fire) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_e_r <= in_elapsed_cycles;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_adv) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      res_r <= res_nxt;
    end
  end

  // Timing state: advance per transaction, clear when the display turns off
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      line_r <= '0;
    end else if (disp_off_clr) begin
      pos_r  <= '0;
      line_r <= '0;
    end else if (step_fire) begin
      pos_r  <= pos_nxt;
      line_r <= line_nxt;
    end
  end

  assign out_valid            = out_v_r;
  assign out_line_drawn       = res_r.line_drawn;
  assign out_drawn_line       = res_r.drawn_line;
  assign out_hblank_dma_pulse = res_r.hblank_dma_pulse;
  assign out_stat_irq         = res_r.stat_irq;
  assign out_frame_end        = res_r.frame_end;
  assign out_lcd_mode         = res_r.lcd_mode;
  assign out_current_line     = res_r.current_line;
  assign out_line_match       = res_r.line_match;
  assign out_cycles_to_event  = res_r.cycles_to_event;
  assign out_running          = res_r.running;

  // Counters stay inside the frame
  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    line_r <= lcdlm_pkg::LAST_LINE)
    else $error("line counter beyond last line");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= lcdlm_pkg::LAST_POS)
    else $error("line position beyond line length");

  // A disabled display holds its counters
  a_hold_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg.display_enable |=> $stable(pos_r) && $stable(line_r))
    else $error("counters moved while display disabled");

  // A drawn line is always a visible one, and DMA only fires with a draw
  a_drawn_visible: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.line_drawn |-> res_r.drawn_line < lcdlm_pkg::VBLANK_FIRST)
    else $error("drawn line in vertical blanking");

  a_dma_with_draw: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.hblank_dma_pulse |-> res_r.line_drawn)
    else $error("hblank DMA without a draw point");

endmodule

`default_nettype wire
